FILE: sv/pfa_pkg.sv
// Shared types and constants for the page frame allocator.
// Used by pfa_bump, page_frame_allocator and the testbench; depends on nothing.
package pfa_pkg;

    // Width of the configuration register index, wide enough to carry indexes
    // past the last register (those writes are ignored).
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REGION_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_REGION_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_REGION_END   = 3'd3;

    // Request codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

endpackage

FILE: sv/pfa_stack_mem.sv
// Free stack storage: one write port and one read port with registered read data.
// Depends on nothing; instantiated by page_frame_allocator.
module pfa_stack_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pfa_bump.sv
// Bump pointer and region limit registers with the allocate decision logic.
// Depends on pfa_pkg; instantiated by page_frame_allocator.
module pfa_bump #(
    parameter int FRAME_BITS = 36
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FRAME_BITS-1:0]        i_cfg_data,
    input  logic                         i_take,
    output logic [FRAME_BITS-1:0]        o_frame,
    output logic                         o_exhausted
);

    logic [FRAME_BITS-1:0] r_next;
    logic [FRAME_BITS-1:0] n_next;
    logic [FRAME_BITS-1:0] r_first_end;
    logic [FRAME_BITS-1:0] r_second_start;
    logic [FRAME_BITS-1:0] r_second_end;
    logic                  w_in_hole;

    assign o_exhausted = r_next > r_second_end;
    // A pointer in the hole between the regions jumps to the second region.
    assign w_in_hole   = (r_next >= r_first_end) && (r_next < r_second_start);
    assign o_frame     = w_in_hole ? r_second_start : r_next;

    always_comb begin
        n_next = r_next;
        if (i_cfg_we && (i_cfg_index == pfa_pkg::CFG_START_FRAME)) begin
            n_next = i_cfg_data;
        end else if (i_take) begin
            n_next = o_frame + FRAME_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next         <= FRAME_BITS'(1);
            r_first_end    <= '0;
            r_second_start <= '0;
            r_second_end   <= '0;
        end else begin
            r_next <= n_next;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pfa_pkg::CFG_FIRST_REGION_END:    r_first_end    <= i_cfg_data;
                    pfa_pkg::CFG_SECOND_REGION_START: r_second_start <= i_cfg_data;
                    pfa_pkg::CFG_SECOND_REGION_END:   r_second_end   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: sv/page_frame_allocator.sv
// Page frame allocator: one request item in, one result item out, usually one per cycle.
// An accepted item passes through the result stage and then the output register; a pop
// takes its frame from the registered stack memory read, which the result stage absorbs,
// so throughput is one item per cycle while the output is not stalled. Synchronous
// active-low reset clears the bump pointer to one, the region limits and the stack count
// to zero; stack contents are left as they are and never read before being written.
module page_frame_allocator #(
    parameter int FREE_DEPTH = 1024,
    parameter int FRAME_BITS = 36
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [FRAME_BITS-1:0]         i_freed_frame,
    // Result channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [FRAME_BITS-1:0]         o_granted_frame,
    output logic [1:0]                    o_status,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FRAME_BITS-1:0]         i_cfg_data
);

    localparam int AW = $clog2(FREE_DEPTH);
    localparam int CW = $clog2(FREE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(FREE_DEPTH);

    // Stack fill count; entries below it hold freed frames.
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         w_count_dec;

    // Result stage: the accepted item waiting for the output register. A pop takes its frame
    // from the memory read register, which holds until the next read.
    logic                  r_pend;
    logic                  r_pend_pop;
    logic [FRAME_BITS-1:0] r_pend_frame;
    pfa_pkg::t_status      r_pend_status;

    // Output register.
    logic                  r_out_valid;
    logic [FRAME_BITS-1:0] r_out_frame;
    pfa_pkg::t_status      r_out_status;

    logic                  w_out_free;
    logic                  w_move;
    logic                  w_acc;
    logic                  w_alloc;
    logic                  w_pop;
    logic                  w_push;
    logic                  w_take;
    logic [FRAME_BITS-1:0] w_bump_frame;
    logic                  w_exhausted;
    logic [FRAME_BITS-1:0] w_rdata;
    logic [FRAME_BITS-1:0] n_pend_frame;
    pfa_pkg::t_status      n_pend_status;

    // The result stage drains when the output register is empty or being taken,
    // and a new item enters whenever the result stage is empty or draining.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_move     = r_pend && w_out_free;
    assign o_stall    = r_pend && !w_out_free;
    assign w_acc      = i_valid && !o_stall;

    assign w_alloc     = w_acc && (i_command == pfa_pkg::CMD_ALLOC);
    assign w_pop       = w_alloc && (r_count != '0);
    assign w_take      = w_alloc && (r_count == '0) && !w_exhausted;
    assign w_push      = w_acc && (i_command == pfa_pkg::CMD_FREE) && (r_count != FULL_COUNT);
    assign w_count_dec = r_count - CW'(1);

    always_comb begin
        n_count = r_count;
        if (w_pop) begin
            n_count = w_count_dec;
        end else if (w_push) begin
            n_count = r_count + CW'(1);
        end
    end

    // Result of a request that does not need the memory.
    always_comb begin
        n_pend_frame  = '0;
        n_pend_status = pfa_pkg::ST_OK;
        if (i_command == pfa_pkg::CMD_ALLOC) begin
            if (w_exhausted) begin
                n_pend_status = pfa_pkg::ST_EXHAUSTED;
            end else begin
                n_pend_frame = w_bump_frame;
            end
        end else if (r_count == FULL_COUNT) begin
            n_pend_status = pfa_pkg::ST_FULL;
        end
    end

    pfa_stack_mem #(
        .DEPTH (FREE_DEPTH),
        .WIDTH (FRAME_BITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_freed_frame),
        .i_re    (w_pop),
        .i_raddr (w_count_dec[AW-1:0]),
        .o_rdata (w_rdata)
    );

    pfa_bump #(
        .FRAME_BITS (FRAME_BITS)
    ) u_bump (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (w_take),
        .o_frame     (w_bump_frame),
        .o_exhausted (w_exhausted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_pend <= 1'b1;
            end else if (w_move) begin
                r_pend <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pend_pop    <= w_pop;
            r_pend_frame  <= n_pend_frame;
            r_pend_status <= n_pend_status;
        end
        if (w_move) begin
            r_out_frame  <= r_pend_pop ? w_rdata : r_pend_frame;
            r_out_status <= r_pend_pop ? pfa_pkg::ST_OK : r_pend_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_granted_frame = r_out_frame;
    assign o_status        = r_out_status;

endmodule

FILE: tb/page_frame_allocator_test.sv
// Self-checking testbench for page_frame_allocator: allocate and free requests with
// random sender gaps and receiver stalls, checked against an in-bench allocator model.
// Depends on pfa_pkg and page_frame_allocator.
module page_frame_allocator_test;

    localparam int FRAME_BITS = 36;
    localparam int FREE_DEPTH = 1024;

    typedef logic [pfa_pkg::CFG_IDX_W-1:0] t_cfg_index;

    // Register indexes past the last register; the block must ignore writes to them.
    localparam t_cfg_index CFG_UNUSED_LO = 3'd4;
    localparam t_cfg_index CFG_UNUSED_HI = 3'd7;

    // Cycles allowed after the last result for stray results to show up.
    localparam int TAIL_CYCLES = 8;

    typedef logic [FRAME_BITS-1:0] t_frame;

    localparam t_frame FRAME_MAX = '1;

    // One result item: the granted frame and the status code.
    typedef struct packed {
        t_frame           frame;
        pfa_pkg::t_status status;
    } t_grant;

    // One request item as queued for the driver. When hold_for_drain is set, the
    // driver does not present this item until every outstanding result has arrived.
    typedef struct {
        logic   command;
        t_frame frame;
        bit     hold_for_drain;
    } t_request;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_command = pfa_pkg::CMD_ALLOC;
    t_frame     i_freed_frame = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_frame     o_granted_frame;
    logic [1:0] o_status;
    logic       i_cfg_we = 1'b0;
    t_cfg_index i_cfg_index = pfa_pkg::CFG_START_FRAME;
    t_frame     i_cfg_data = '0;

    page_frame_allocator #(
        .FREE_DEPTH(FREE_DEPTH),
        .FRAME_BITS(FRAME_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_freed_frame  (i_freed_frame),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_granted_frame(o_granted_frame),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Allocator model state. The register copies start at their reset values and
    // are updated whenever the bench writes a register.
    t_frame model_first_end = 0;
    t_frame model_second_start = 0;
    t_frame model_second_end = 0;
    t_frame bump_ptr = 1;
    t_frame free_frames [FREE_DEPTH];
    int     free_fill = 0;

    // Requests waiting for the driver, and grants waiting for the monitor.
    t_request request_q[$];
    t_grant   grants_due[$];

    int n_queued = 0;
    int n_accepted = 0;
    int mismatches = 0;
    int n_bumped = 0;
    int n_hole_jumps = 0;
    int n_popped = 0;
    int n_refused = 0;
    int n_dropped = 0;

    // Idling switches, set per phase by the stimulus process.
    bit sender_idles = 1'b0;
    bit receiver_idles = 1'b0;
    int gap_left = 0;
    int stall_left = 0;

    function automatic t_frame random_frame();
        return t_frame'({$urandom(), $urandom()});
    endfunction

    // Serves one request on the model and returns the grant it produces. An allocate
    // pops the last freed frame first; only with an empty stack does it use the bump
    // pointer, which skips the hole between the regions and refuses past the end of
    // the second region without changing anything.
    function automatic t_grant serve_request(logic command, t_frame freed);
        t_grant grant;
        t_frame pick;
        grant.frame = '0;
        grant.status = pfa_pkg::ST_OK;
        if (command == pfa_pkg::CMD_FREE) begin
            if (free_fill < FREE_DEPTH) begin
                free_frames[free_fill] = freed;
                free_fill++;
            end else begin
                grant.status = pfa_pkg::ST_FULL;
                n_dropped++;
            end
        end else if (free_fill > 0) begin
            free_fill--;
            grant.frame = free_frames[free_fill];
            n_popped++;
        end else if (bump_ptr > model_second_end) begin
            grant.status = pfa_pkg::ST_EXHAUSTED;
            n_refused++;
        end else begin
            pick = bump_ptr;
            // A pointer in the hole lands on the second region's start; that frame
            // is handed out even if it lies past the second region's end.
            if (pick >= model_first_end && pick < model_second_start) begin
                pick = model_second_start;
                n_hole_jumps++;
            end
            grant.frame = pick;
            bump_ptr = pick + 1'b1;
            n_bumped++;
        end
        return grant;
    endfunction

    // Driver. On each accepted request it predicts the grant, then either holds a stalled item,
    // inserts a gap, idles while no request may go, or presents the next queued request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (!sender_idles) begin
                gap_left = 0;
            end
            if (i_valid && !o_stall) begin
                grants_due.push_back(serve_request(i_command, i_freed_frame));
                n_accepted++;
            end
            // A stalled item stays on the port untouched.
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (request_q.size() == 0 ||
                             (request_q[0].hold_for_drain && grants_due.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_command <= request_q[0].command;
                    i_freed_frame <= request_q[0].frame;
                    void'(request_q.pop_front());
                    if (sender_idles && $urandom_range(0, 9) == 0) begin
                        gap_left = $urandom_range(1, 16);
                    end
                end
            end
        end
    end

    // Monitor. Every accepted result is checked against the oldest predicted grant;
    // the stall for the next cycle is chosen in random bursts while the receiver idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (grants_due.size() == 0) begin
                    $display("%0t: unexpected result: frame %h status %0d", $time,
                             o_granted_frame, o_status);
                    mismatches++;
                end else begin
                    if (o_granted_frame !== grants_due[0].frame) begin
                        $display("%0t: granted frame mismatch: expected %h, actual %h",
                                 $time, grants_due[0].frame, o_granted_frame);
                        mismatches++;
                    end
                    if (o_status !== grants_due[0].status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, grants_due[0].status, o_status);
                        mismatches++;
                    end
                    void'(grants_due.pop_front());
                end
            end
            if (!receiver_idles) begin
                stall_left = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 15);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic void queue_request(logic command, t_frame frame, bit hold = 1'b0);
        t_request req;
        req.command = command;
        req.frame = frame;
        req.hold_for_drain = hold;
        request_q.push_back(req);
        n_queued++;
    endfunction

    // Returns at a rising edge once every queued request has been accepted and every
    // grant has come back, so the block is idle and registers may be written.
    task automatic wait_quiet();
        do begin
            @(posedge i_clk);
        end while (n_accepted != n_queued || grants_due.size() != 0);
    endtask

    // Writes one register; called at a rising edge while the block is idle. The
    // model is updated at once since no request can be accepted before the write.
    task automatic write_register(input t_cfg_index index, input t_frame value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        case (index)
            pfa_pkg::CFG_START_FRAME: begin
                bump_ptr = value;
            end
            pfa_pkg::CFG_FIRST_REGION_END: begin
                model_first_end = value;
            end
            pfa_pkg::CFG_SECOND_REGION_START: begin
                model_second_start = value;
            end
            pfa_pkg::CFG_SECOND_REGION_END: begin
                model_second_end = value;
            end
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regions(input t_frame start, input t_frame first_end,
                               input t_frame second_start, input t_frame second_end);
        write_register(pfa_pkg::CFG_START_FRAME, start);
        write_register(pfa_pkg::CFG_FIRST_REGION_END, first_end);
        write_register(pfa_pkg::CFG_SECOND_REGION_START, second_start);
        write_register(pfa_pkg::CFG_SECOND_REGION_END, second_end);
        i_cfg_we <= 1'b0;
    endtask

    // One random phase: small random regions placed low, near the top of the frame
    // space or anywhere, then a mix of allocates and frees whose freed frames mostly fall
    // near the regions. Some phases keep the bump pointer from the phase before.
    task automatic random_phase(input int count, input bit idles);
        t_frame base;
        t_frame first_end;
        t_frame second_start;
        t_frame second_end;
        t_frame start;
        int     alloc_pct;
        case ($urandom_range(0, 3))
            0, 1: begin
                base = t_frame'($urandom_range(0, 2000));
            end
            2: begin
                base = FRAME_MAX - t_frame'($urandom_range(0, 200));
            end
            default: begin
                base = random_frame();
            end
        endcase
        first_end = base + t_frame'($urandom_range(0, 24));
        second_start = first_end + t_frame'($urandom_range(0, 40));
        second_end = second_start + t_frame'($urandom_range(0, 24));
        start = ($urandom_range(0, 3) == 0) ? first_end + t_frame'($urandom_range(0, 3))
                                             : base;
        if ($urandom_range(0, 3) == 0) begin
            write_register(t_cfg_index'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                           random_frame());
        end
        if ($urandom_range(0, 4) != 0) begin
            write_register(pfa_pkg::CFG_START_FRAME, start);
        end
        write_register(pfa_pkg::CFG_FIRST_REGION_END, first_end);
        write_register(pfa_pkg::CFG_SECOND_REGION_START, second_start);
        write_register(pfa_pkg::CFG_SECOND_REGION_END, second_end);
        i_cfg_we <= 1'b0;
        sender_idles = idles;
        receiver_idles = idles;
        alloc_pct = $urandom_range(30, 75);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                queue_request(pfa_pkg::CMD_ALLOC, random_frame(),
                              $urandom_range(0, 49) == 0);
            end else if ($urandom_range(0, 3) != 0) begin
                queue_request(pfa_pkg::CMD_FREE, base + t_frame'($urandom_range(0, 100)));
            end else begin
                queue_request(pfa_pkg::CMD_FREE, random_frame());
            end
        end
        wait_quiet();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the pointer (one) already lies past the second region's
        // end (zero), so a bump allocate is refused. Frees at both ends of the frame
        // range come back in LIFO order.
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        queue_request(pfa_pkg::CMD_ALLOC, FRAME_MAX);
        queue_request(pfa_pkg::CMD_FREE, '0);
        queue_request(pfa_pkg::CMD_FREE, FRAME_MAX);
        queue_request(pfa_pkg::CMD_ALLOC, '0);
        queue_request(pfa_pkg::CMD_ALLOC, '0);
        queue_request(pfa_pkg::CMD_ALLOC, '0);
        wait_quiet();

        // Writes to unused indexes must change nothing. Then walk the first region,
        // jump the hole, run the second region dry, and pop alternating bit patterns.
        // The first free waits until every grant before it has come back.
        write_register(CFG_UNUSED_LO, '0);
        write_register(CFG_UNUSED_HI, FRAME_MAX);
        set_regions(10, 12, 20, 22);
        repeat (6) queue_request(pfa_pkg::CMD_ALLOC, '0);
        queue_request(pfa_pkg::CMD_FREE, 36'h5_5555_5555, 1'b1);
        queue_request(pfa_pkg::CMD_FREE, 36'hA_AAAA_AAAA);
        queue_request(pfa_pkg::CMD_ALLOC, '0);
        queue_request(pfa_pkg::CMD_ALLOC, '0);
        wait_quiet();

        // The pointer wraps from the top frame to zero. The first request waits for
        // the block to drain completely before it is presented.
        set_regions(FRAME_MAX - 1'b1, '0, '0, FRAME_MAX);
        queue_request(pfa_pkg::CMD_ALLOC, '0, 1'b1);
        repeat (3) queue_request(pfa_pkg::CMD_ALLOC, '0);
        wait_quiet();

        // A hole jump whose target lies past the second region's end is still
        // granted; the next allocate is refused.
        set_regions(5, 5, 50, 30);
        queue_request(pfa_pkg::CMD_ALLOC, '0);
        queue_request(pfa_pkg::CMD_ALLOC, '0);
        wait_quiet();

        // Random phases, alternating between idling and back-to-back traffic.
        for (int p = 0; p < 5; p++) begin
            random_phase(50, p % 2 == 0);
        end

        // Push a run of frees, then drain the stack and the bump regions until
        // allocates are refused.
        set_regions(100, 110, 200, 205);
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        for (int k = 0; k < 30; k++) begin
            queue_request(pfa_pkg::CMD_FREE, ($urandom_range(0, 3) == 0) ? random_frame()
                                             : t_frame'($urandom_range(100, 205)));
        end
        repeat (free_fill + 50) queue_request(pfa_pkg::CMD_ALLOC, '0);
        wait_quiet();

        // Last stretch at full rate on both sides.
        random_phase(55, 1'b0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests: %0d bump grants (%0d across the hole), %0d stack pops,",
                 n_accepted, n_bumped, n_hole_jumps, n_popped);
        $display("%0d exhausted refusals and %0d frees dropped on a full free stack.",
                 n_refused, n_dropped);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Far above the slowest correct run, even with every item hitting the longest
    // sender gap and receiver stall.
    initial begin
        #20_000_000;
        $display("Timed out with %0d grants still outstanding.", grants_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
